// ===== sv/nnrs_pkg.sv =====
// ----------------------------------------------------------------------------
// nnrs_pkg
// Shared constants and types for the nearest-neighbor RGB scaler: pixel and
// store geometry, register map and command codes.
// ----------------------------------------------------------------------------
package nnrs_pkg;

    localparam int PIXEL_BITS     = 24;
    localparam int MAX_SRC_WIDTH  = 64;
    localparam int MAX_SRC_HEIGHT = 64;
    localparam int MAX_DST        = 4096;

    localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // Register field widths.
    localparam int SRC_DIM_W = 7;
    localparam int DST_DIM_W = 13;
    localparam int COORD_W   = 12;

    // Source coordinate (quotient) width covers the larger source dimension.
    localparam int MAX_SRC_DIM = (MAX_SRC_WIDTH > MAX_SRC_HEIGHT) ?
                                 MAX_SRC_WIDTH : MAX_SRC_HEIGHT;
    localparam int Q_W    = (MAX_SRC_DIM > 1) ? $clog2(MAX_SRC_DIM) : 1;
    localparam int CNT_W  = (Q_W > 1) ? $clog2(Q_W) : 1;
    localparam int DIV_W  = DST_DIM_W + Q_W;
    localparam int IDX_W  = Q_W + SRC_DIM_W + 1;
    localparam int TOTAL_W = 2 * SRC_DIM_W;

    // APB register map.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam int REG_IDX_W  = 2;

    typedef logic [REG_IDX_W-1:0] reg_idx_t;
    localparam reg_idx_t REG_SRC_WIDTH  = 2'd0;
    localparam reg_idx_t REG_SRC_HEIGHT = 2'd1;
    localparam reg_idx_t REG_DST_WIDTH  = 2'd2;
    localparam reg_idx_t REG_DST_HEIGHT = 2'd3;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EMIT = 1'b1;

    typedef logic [PIXEL_BITS-1:0] pixel_t;
    typedef logic [ADDR_W-1:0]     store_addr_t;

endpackage

// ===== sv/nearest_neighbor_rgb_scaler_core.sv =====
// ----------------------------------------------------------------------------
// nearest_neighbor_rgb_scaler_core
// Nearest-neighbor scaler for 24-bit RGB pixels with a single-port frame
// store, an APB register port and valid/ready input and output channels.
// ----------------------------------------------------------------------------
// A load transaction writes pixel_in into the frame store at the running load
// address, so loads stream at one per cycle while no emit is in progress.
// An emit transaction first runs the restoring dividers that form the source
// column and row (one quotient bit per cycle each), then forms the store
// address and reads the frame store, then moves the read data into the output
// register and returns to idle before the next transaction is accepted; an
// emit whose result finds the output register still occupied waits in its
// read step until the result is taken. While an emit is in progress no new
// transaction is accepted; the output register lets the next transaction
// enter while a result waits to be taken. Size registers of zero read back
// as written but act as one, and oversized values act as the maximum.
// Registers should only be written while idle.
module nearest_neighbor_rgb_scaler_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [nnrs_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [nnrs_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [nnrs_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               command,
    input  logic [nnrs_pkg::PIXEL_BITS-1:0]    pixel_in,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [nnrs_pkg::PIXEL_BITS-1:0]    pixel_out,
    output logic                               end_of_row,
    output logic                               end_of_frame
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_ADDR,
        S_READ
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [nnrs_pkg::SRC_DIM_W-1:0] src_width_reg;
    logic [nnrs_pkg::SRC_DIM_W-1:0] src_height_reg;
    logic [nnrs_pkg::DST_DIM_W-1:0] dst_width_reg;
    logic [nnrs_pkg::DST_DIM_W-1:0] dst_height_reg;

    // Position state.
    nnrs_pkg::store_addr_t            load_addr_reg;
    logic [nnrs_pkg::COORD_W-1:0]     dest_col_reg;
    logic [nnrs_pkg::COORD_W-1:0]     dest_row_reg;

    // Divider state.
    logic [nnrs_pkg::DIV_W-1:0]       rem_x_reg;
    logic [nnrs_pkg::DIV_W-1:0]       rem_y_reg;
    logic [nnrs_pkg::DIV_W-1:0]       dvs_x_reg;
    logic [nnrs_pkg::DIV_W-1:0]       dvs_y_reg;
    logic [nnrs_pkg::Q_W-1:0]         qx_reg;
    logic [nnrs_pkg::Q_W-1:0]         qy_reg;
    logic [nnrs_pkg::CNT_W-1:0]       cnt_reg;
    logic [nnrs_pkg::SRC_DIM_W-1:0]   sw_hold_reg;
    logic                             eor_reg;
    logic                             eof_reg;

    // Output register.
    logic                             out_valid_reg;
    nnrs_pkg::pixel_t                 pixel_out_reg;
    logic                             end_of_row_reg;
    logic                             end_of_frame_reg;

    // Frame store.
    nnrs_pkg::pixel_t                 store_mem [nnrs_pkg::STORE_DEPTH];
    nnrs_pkg::pixel_t                 rd_data_reg;

    logic                             cfg_we;
    nnrs_pkg::reg_idx_t               cfg_idx;
    logic                             in_fire;
    logic                             load_fire;
    logic                             emit_fire;
    logic                             out_load;

    logic [nnrs_pkg::SRC_DIM_W-1:0]   sw;
    logic [nnrs_pkg::SRC_DIM_W-1:0]   sh;
    logic [nnrs_pkg::DST_DIM_W-1:0]   dw;
    logic [nnrs_pkg::DST_DIM_W-1:0]   dh;
    logic [nnrs_pkg::TOTAL_W-1:0]     total;

    nnrs_pkg::store_addr_t            load_addr_cur;
    logic [nnrs_pkg::ADDR_W:0]        load_addr_inc;
    nnrs_pkg::store_addr_t            load_addr_next;

    logic [nnrs_pkg::COORD_W-1:0]     x_cur;
    logic [nnrs_pkg::COORD_W-1:0]     y_cur;
    logic                             eor;
    logic                             eof;
    logic [nnrs_pkg::COORD_W-1:0]     dest_col_next;
    logic [nnrs_pkg::COORD_W-1:0]     dest_row_next;
    logic [nnrs_pkg::DIV_W-1:0]       prod_x;
    logic [nnrs_pkg::DIV_W-1:0]       prod_y;

    logic                             bit_x;
    logic                             bit_y;
    logic [nnrs_pkg::IDX_W-1:0]       idx_full;
    nnrs_pkg::store_addr_t            rd_addr;
    logic                             rd_en;

    // ------------------------------------------------------------------
    // APB register port
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[nnrs_pkg::APB_ADDR_W-1:2];
    assign cfg_we  = psel & penable & pwrite;

    always_comb
    begin
        case (cfg_idx)
            nnrs_pkg::REG_SRC_WIDTH:
                prdata = nnrs_pkg::APB_DATA_W'(src_width_reg);
            nnrs_pkg::REG_SRC_HEIGHT:
                prdata = nnrs_pkg::APB_DATA_W'(src_height_reg);
            nnrs_pkg::REG_DST_WIDTH:
                prdata = nnrs_pkg::APB_DATA_W'(dst_width_reg);
            nnrs_pkg::REG_DST_HEIGHT:
                prdata = nnrs_pkg::APB_DATA_W'(dst_height_reg);
            default:
                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Effective sizes: zero acts as one, oversized values saturate.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (src_width_reg == '0)
            sw = nnrs_pkg::SRC_DIM_W'(1);
        else if (src_width_reg > nnrs_pkg::SRC_DIM_W'(nnrs_pkg::MAX_SRC_WIDTH))
            sw = nnrs_pkg::SRC_DIM_W'(nnrs_pkg::MAX_SRC_WIDTH);
        else
            sw = src_width_reg;

        if (src_height_reg == '0)
            sh = nnrs_pkg::SRC_DIM_W'(1);
        else if (src_height_reg > nnrs_pkg::SRC_DIM_W'(nnrs_pkg::MAX_SRC_HEIGHT))
            sh = nnrs_pkg::SRC_DIM_W'(nnrs_pkg::MAX_SRC_HEIGHT);
        else
            sh = src_height_reg;

        if (dst_width_reg == '0)
            dw = nnrs_pkg::DST_DIM_W'(1);
        else if (dst_width_reg > nnrs_pkg::DST_DIM_W'(nnrs_pkg::MAX_DST))
            dw = nnrs_pkg::DST_DIM_W'(nnrs_pkg::MAX_DST);
        else
            dw = dst_width_reg;

        if (dst_height_reg == '0)
            dh = nnrs_pkg::DST_DIM_W'(1);
        else if (dst_height_reg > nnrs_pkg::DST_DIM_W'(nnrs_pkg::MAX_DST))
            dh = nnrs_pkg::DST_DIM_W'(nnrs_pkg::MAX_DST);
        else
            dh = dst_height_reg;
    end

    assign total = nnrs_pkg::TOTAL_W'(sw) * nnrs_pkg::TOTAL_W'(sh);

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid & in_ready;
    assign load_fire = in_fire & (command == nnrs_pkg::CMD_LOAD);
    assign emit_fire = in_fire & (command == nnrs_pkg::CMD_EMIT);

    // Load address, restarted when a size change left it out of range.
    always_comb
    begin
        if (nnrs_pkg::TOTAL_W'(load_addr_reg) < total)
            load_addr_cur = load_addr_reg;
        else
            load_addr_cur = '0;
        load_addr_inc = {1'b0, load_addr_cur} + 1'b1;
        if (nnrs_pkg::TOTAL_W'(load_addr_inc) >= total)
            load_addr_next = '0;
        else
            load_addr_next = load_addr_inc[nnrs_pkg::ADDR_W-1:0];
    end

    // Destination position and the row and frame flags.
    always_comb
    begin
        if (nnrs_pkg::DST_DIM_W'(dest_col_reg) < dw)
            x_cur = dest_col_reg;
        else
            x_cur = '0;
        if (nnrs_pkg::DST_DIM_W'(dest_row_reg) < dh)
            y_cur = dest_row_reg;
        else
            y_cur = '0;

        eor = (nnrs_pkg::DST_DIM_W'(x_cur) == (dw - 1'b1));
        eof = eor & (nnrs_pkg::DST_DIM_W'(y_cur) == (dh - 1'b1));

        if (eor)
        begin
            dest_col_next = '0;
            dest_row_next = eof ? '0 : (y_cur + 1'b1);
        end
        else
        begin
            dest_col_next = x_cur + 1'b1;
            dest_row_next = y_cur;
        end

        prod_x = nnrs_pkg::DIV_W'(x_cur) * nnrs_pkg::DIV_W'(sw);
        prod_y = nnrs_pkg::DIV_W'(y_cur) * nnrs_pkg::DIV_W'(sh);
    end

    // ------------------------------------------------------------------
    // Divider step and store address
    // ------------------------------------------------------------------
    assign bit_x = (rem_x_reg >= dvs_x_reg);
    assign bit_y = (rem_y_reg >= dvs_y_reg);

    assign idx_full = nnrs_pkg::IDX_W'(qy_reg) * nnrs_pkg::IDX_W'(sw_hold_reg)
                    + nnrs_pkg::IDX_W'(qx_reg);
    assign rd_addr  = idx_full[nnrs_pkg::ADDR_W-1:0];
    assign rd_en    = (state_reg == S_ADDR);

    assign out_load = (state_reg == S_READ) & (~out_valid_reg | out_ready);

    // ------------------------------------------------------------------
    // Frame store: one write port for loads, one registered read.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (load_fire)
            store_mem[load_addr_cur] <= pixel_in;
        if (rd_en)
            rd_data_reg <= store_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Control, registers and output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            src_width_reg    <= nnrs_pkg::SRC_DIM_W'(64);
            src_height_reg   <= nnrs_pkg::SRC_DIM_W'(64);
            dst_width_reg    <= nnrs_pkg::DST_DIM_W'(64);
            dst_height_reg   <= nnrs_pkg::DST_DIM_W'(64);
            load_addr_reg    <= '0;
            dest_col_reg     <= '0;
            dest_row_reg     <= '0;
            rem_x_reg        <= '0;
            rem_y_reg        <= '0;
            dvs_x_reg        <= '0;
            dvs_y_reg        <= '0;
            qx_reg           <= '0;
            qy_reg           <= '0;
            cnt_reg          <= '0;
            sw_hold_reg      <= '0;
            eor_reg          <= 1'b0;
            eof_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
            pixel_out_reg    <= '0;
            end_of_row_reg   <= 1'b0;
            end_of_frame_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    nnrs_pkg::REG_SRC_WIDTH:
                        src_width_reg <= pwdata[nnrs_pkg::SRC_DIM_W-1:0];
                    nnrs_pkg::REG_SRC_HEIGHT:
                        src_height_reg <= pwdata[nnrs_pkg::SRC_DIM_W-1:0];
                    nnrs_pkg::REG_DST_WIDTH:
                        dst_width_reg <= pwdata[nnrs_pkg::DST_DIM_W-1:0];
                    nnrs_pkg::REG_DST_HEIGHT:
                        dst_height_reg <= pwdata[nnrs_pkg::DST_DIM_W-1:0];
                    default:
                        ;
                endcase
            end

            if (load_fire)
                load_addr_reg <= load_addr_next;

            case (state_reg)
                S_IDLE:
                begin
                    if (emit_fire)
                    begin
                        dest_col_reg <= dest_col_next;
                        dest_row_reg <= dest_row_next;
                        eor_reg      <= eor;
                        eof_reg      <= eof;
                        sw_hold_reg  <= sw;
                        rem_x_reg    <= prod_x;
                        rem_y_reg    <= prod_y;
                        // Divisors start aligned to the top quotient bit.
                        dvs_x_reg    <= nnrs_pkg::DIV_W'(dw) << (nnrs_pkg::Q_W - 1);
                        dvs_y_reg    <= nnrs_pkg::DIV_W'(dh) << (nnrs_pkg::Q_W - 1);
                        qx_reg       <= '0;
                        qy_reg       <= '0;
                        cnt_reg      <= nnrs_pkg::CNT_W'(nnrs_pkg::Q_W - 1);
                        state_reg    <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (bit_x)
                        rem_x_reg <= rem_x_reg - dvs_x_reg;
                    if (bit_y)
                        rem_y_reg <= rem_y_reg - dvs_y_reg;
                    qx_reg    <= nnrs_pkg::Q_W'({qx_reg, bit_x});
                    qy_reg    <= nnrs_pkg::Q_W'({qy_reg, bit_y});
                    dvs_x_reg <= dvs_x_reg >> 1;
                    dvs_y_reg <= dvs_y_reg >> 1;
                    cnt_reg   <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                        state_reg <= S_ADDR;
                end
                S_ADDR:
                begin
                    state_reg <= S_READ;
                end
                S_READ:
                begin
                    if (out_load)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (out_load)
            begin
                out_valid_reg    <= 1'b1;
                pixel_out_reg    <= rd_data_reg;
                end_of_row_reg   <= eor_reg;
                end_of_frame_reg <= eof_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_out    = pixel_out_reg;
    assign end_of_row   = end_of_row_reg;
    assign end_of_frame = end_of_frame_reg;

endmodule

// ===== tb/nearest_neighbor_rgb_scaler_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbor_rgb_scaler_core_test
// Self-checking testbench for the nearest-neighbor RGB scaler core. A short
// table of load and emit transactions runs first under the reset sizes. Three
// no-idle phases then try saturated sizes, zero sizes and one whole small
// frame. Randomly sized phases with random idling follow. Every emit result
// is compared against the table's expected pixel or a scaler model kept inside this file.
// ----------------------------------------------------------------------------
module nearest_neighbor_rgb_scaler_core_test;

    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_REPORTS   = 40;

    typedef struct packed {
        nnrs_pkg::pixel_t pixel;
        logic             row_end;
        logic             frame_end;
    } dest_pixel_t;

    typedef struct packed {
        logic             cmd;
        nnrs_pkg::pixel_t pixel;
        logic             typed;
        dest_pixel_t      want;
    } directed_row_t;

    logic                            clk;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [nnrs_pkg::APB_ADDR_W-1:0] paddr;
    logic [nnrs_pkg::APB_DATA_W-1:0] pwdata;
    logic [nnrs_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;
    logic                            in_valid;
    logic                            in_ready;
    logic                            command;
    nnrs_pkg::pixel_t                pixel_in;
    logic                            out_valid;
    logic                            out_ready;
    nnrs_pkg::pixel_t                pixel_out;
    logic                            end_of_row;
    logic                            end_of_frame;

    // Scaler model state.
    nnrs_pkg::pixel_t               frame_mem [nnrs_pkg::STORE_DEPTH];
    bit                             loaded [nnrs_pkg::STORE_DEPTH];
    int unsigned                    load_ptr = 0;
    int unsigned                    dest_x = 0;
    int unsigned                    dest_y = 0;
    logic [nnrs_pkg::SRC_DIM_W-1:0] src_w_reg = nnrs_pkg::SRC_DIM_W'(64);
    logic [nnrs_pkg::SRC_DIM_W-1:0] src_h_reg = nnrs_pkg::SRC_DIM_W'(64);
    logic [nnrs_pkg::DST_DIM_W-1:0] dst_w_reg = nnrs_pkg::DST_DIM_W'(64);
    logic [nnrs_pkg::DST_DIM_W-1:0] dst_h_reg = nnrs_pkg::DST_DIM_W'(64);

    dest_pixel_t pending_pixels [$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    bit          quiet = 1'b0;
    int          rx_hold = 0;

    // Under the reset sizes the mapping is one to one, so every emit returns
    // the pixel loaded at the same raster position.
    directed_row_t directed_rows [18] = '{
        '{nnrs_pkg::CMD_LOAD, 24'h000000, 1'b0, '0},
        '{nnrs_pkg::CMD_LOAD, 24'hFFFFFF, 1'b0, '0},
        '{nnrs_pkg::CMD_LOAD, 24'h800000, 1'b0, '0},
        '{nnrs_pkg::CMD_LOAD, 24'h000001, 1'b0, '0},
        '{nnrs_pkg::CMD_LOAD, 24'h7FFFFF, 1'b0, '0},
        '{nnrs_pkg::CMD_LOAD, 24'hAAAAAA, 1'b0, '0},
        '{nnrs_pkg::CMD_LOAD, 24'h555555, 1'b0, '0},
        '{nnrs_pkg::CMD_EMIT, 24'hFFFFFF, 1'b1, '{24'h000000, 1'b0, 1'b0}},
        '{nnrs_pkg::CMD_EMIT, 24'h000000, 1'b1, '{24'hFFFFFF, 1'b0, 1'b0}},
        '{nnrs_pkg::CMD_EMIT, 24'hFFFFFF, 1'b1, '{24'h800000, 1'b0, 1'b0}},
        '{nnrs_pkg::CMD_EMIT, 24'h000000, 1'b1, '{24'h000001, 1'b0, 1'b0}},
        '{nnrs_pkg::CMD_EMIT, 24'h123456, 1'b1, '{24'h7FFFFF, 1'b0, 1'b0}},
        '{nnrs_pkg::CMD_EMIT, 24'h654321, 1'b1, '{24'hAAAAAA, 1'b0, 1'b0}},
        '{nnrs_pkg::CMD_EMIT, 24'h0F0F0F, 1'b1, '{24'h555555, 1'b0, 1'b0}},
        '{nnrs_pkg::CMD_LOAD, 24'hC0FFEE, 1'b0, '0},
        '{nnrs_pkg::CMD_EMIT, 24'hF0F0F0, 1'b1, '{24'hC0FFEE, 1'b0, 1'b0}},
        '{nnrs_pkg::CMD_LOAD, 24'h123456, 1'b0, '0},
        '{nnrs_pkg::CMD_EMIT, 24'h000000, 1'b1, '{24'h123456, 1'b0, 1'b0}}
    };

    nearest_neighbor_rgb_scaler_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .pixel_in     (pixel_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_out    (pixel_out),
        .end_of_row   (end_of_row),
        .end_of_frame (end_of_frame)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // A size register of zero acts as one; oversized values saturate.
    function automatic int unsigned act_size(int unsigned value, int unsigned top);
        return (value == 0) ? 1 : ((value > top) ? top : value);
    endfunction

    // Store index that the next emit transaction reads.
    function automatic int unsigned emit_index();
        int unsigned sw, sh, dw, dh, x, y;
        sw = act_size(32'(src_w_reg), nnrs_pkg::MAX_SRC_WIDTH);
        sh = act_size(32'(src_h_reg), nnrs_pkg::MAX_SRC_HEIGHT);
        dw = act_size(32'(dst_w_reg), nnrs_pkg::MAX_DST);
        dh = act_size(32'(dst_h_reg), nnrs_pkg::MAX_DST);
        x  = (dest_x < dw) ? dest_x : 0;
        y  = (dest_y < dh) ? dest_y : 0;
        return ((y * sh / dh) * sw + x * sw / dw) % nnrs_pkg::STORE_DEPTH;
    endfunction

    // Applies one accepted transaction to the model and returns the pixel
    // an emit produces.
    function automatic dest_pixel_t advance_scaler(logic cmd, nnrs_pkg::pixel_t pix);
        int unsigned total, dw, dh, x, y, idx;
        dest_pixel_t res;
        total = act_size(32'(src_w_reg), nnrs_pkg::MAX_SRC_WIDTH)
              * act_size(32'(src_h_reg), nnrs_pkg::MAX_SRC_HEIGHT);
        dw    = act_size(32'(dst_w_reg), nnrs_pkg::MAX_DST);
        dh    = act_size(32'(dst_h_reg), nnrs_pkg::MAX_DST);
        res   = '0;
        if (cmd == nnrs_pkg::CMD_LOAD)
        begin
            idx = (load_ptr < total) ? load_ptr : 0;
            frame_mem[idx] = pix;
            loaded[idx]    = 1'b1;
            load_ptr       = (idx + 1 >= total) ? 0 : idx + 1;
        end
        else
        begin
            x   = (dest_x < dw) ? dest_x : 0;
            y   = (dest_y < dh) ? dest_y : 0;
            idx = emit_index();
            res.pixel     = frame_mem[idx];
            res.row_end   = (x == dw - 1);
            res.frame_end = res.row_end && (y == dh - 1);
            if (res.row_end)
            begin
                dest_x = 0;
                dest_y = res.frame_end ? 0 : y + 1;
            end
            else
            begin
                dest_x = x + 1;
                dest_y = y;
            end
        end
        return res;
    endfunction

    task automatic send_item(input logic cmd, input nnrs_pkg::pixel_t pix,
                             input logic typed, input dest_pixel_t want);
        int          gap;
        dest_pixel_t got;
        gap = quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        pixel_in <= pix;
        do @(posedge clk); while (!in_ready);
        got = advance_scaler(cmd, pix);
        if (cmd == nnrs_pkg::CMD_EMIT)
            pending_pixels.push_back(typed ? want : got);
    endtask

    // An emit that would read a never-loaded entry is turned into a load.
    task automatic random_item(input int emit_pct);
        logic cmd;
        cmd = ($urandom_range(0, 99) < emit_pct) ? nnrs_pkg::CMD_EMIT : nnrs_pkg::CMD_LOAD;
        if (cmd == nnrs_pkg::CMD_EMIT && !loaded[emit_index()])
            cmd = nnrs_pkg::CMD_LOAD;
        send_item(cmd, nnrs_pkg::pixel_t'($urandom), 1'b0, '0);
    endtask

    // Loads produce no result, so a settling wait follows the last result.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input nnrs_pkg::reg_idx_t idx, input int unsigned value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            nnrs_pkg::REG_SRC_WIDTH:  src_w_reg = value[nnrs_pkg::SRC_DIM_W-1:0];
            nnrs_pkg::REG_SRC_HEIGHT: src_h_reg = value[nnrs_pkg::SRC_DIM_W-1:0];
            nnrs_pkg::REG_DST_WIDTH:  dst_w_reg = value[nnrs_pkg::DST_DIM_W-1:0];
            nnrs_pkg::REG_DST_HEIGHT: dst_h_reg = value[nnrs_pkg::DST_DIM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic run_phase(input int unsigned sw, input int unsigned sh,
                             input int unsigned dw, input int unsigned dh,
                             input bit fill, input int count, input int emit_pct);
        int unsigned total;
        wait_idle();
        write_reg(nnrs_pkg::REG_SRC_WIDTH, sw);
        write_reg(nnrs_pkg::REG_SRC_HEIGHT, sh);
        write_reg(nnrs_pkg::REG_DST_WIDTH, dw);
        write_reg(nnrs_pkg::REG_DST_HEIGHT, dh);
        total = act_size(sw, nnrs_pkg::MAX_SRC_WIDTH) * act_size(sh, nnrs_pkg::MAX_SRC_HEIGHT);
        if (fill)
            repeat (total) send_item(nnrs_pkg::CMD_LOAD, nnrs_pkg::pixel_t'($urandom), 1'b0, '0);
        repeat (count) random_item(emit_pct);
    endtask

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (got !== want)
        begin
            if (mismatch_count < MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %0h, got %0h",
                         $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        dest_pixel_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                if (mismatch_count < MAX_REPORTS)
                    $display("%0t ns: unexpected result, expected none, got %06h",
                             $time, pixel_out);
                mismatch_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                report_field("pixel_out", 32'(want.pixel), 32'(pixel_out));
                report_field("end_of_row", 32'(want.row_end), 32'(end_of_row));
                report_field("end_of_frame", 32'(want.frame_end), 32'(end_of_frame));
            end
        end
    end

    // Receiver: a random stall before each result, lengthened once by a long
    // hold on request.
    initial
    begin
        int stall;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 14);
            if (rx_hold > 0)
            begin
                stall   = stall + rx_hold;
                rx_hold = 0;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int unsigned sw, sh, dw, dh;
        int          pick;
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        in_valid <= 1'b0;
        command  <= nnrs_pkg::CMD_LOAD;
        pixel_in <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].cmd, directed_rows[i].pixel,
                      directed_rows[i].typed, directed_rows[i].want);

        // Size extremes without idling: oversized values on every register,
        // zero on every register, and one whole small frame.
        quiet = 1'b1;
        run_phase(127, 127, 8191, 8191, 1'b0, 40, 100);
        run_phase(0, 0, 0, 0, 1'b0, 10, 100);
        run_phase(8, 2, 16, 3, 1'b1, 48, 100);
        quiet = 1'b0;

        for (int p = 0; p < 12; p++)
        begin
            pick = $urandom_range(0, 9);
            sw = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(9, 127) : $urandom_range(1, 8);
            pick = $urandom_range(0, 9);
            sh = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(9, 127) : $urandom_range(1, 8);
            pick = $urandom_range(0, 9);
            dw = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(17, 8191) : $urandom_range(1, 16);
            pick = $urandom_range(0, 9);
            dh = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(17, 8191) : $urandom_range(1, 16);
            // The receiver holds off while emit transactions keep coming, so the
            // core fills up and stalls its input.
            if (p == 2)
            begin
                rx_hold = 300;
                run_phase(4, 4, 8, 8, 1'b1, 40, 95);
            end
            else
                run_phase(sw, sh, dw, dh, 1'b0, 20, 70);
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
